// File: sv/bdq_pkg.sv
// shared types and constants for the bounded deque
package bdq_pkg;

    // field widths of the stream beats
    localparam int KIND_W     = 3;
    localparam int VALUE_W    = 32;
    localparam int POS_W      = 4;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;
    localparam int CAP_W      = 5;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    // defaults for the top level parameters
    localparam int DEF_DEPTH      = 16;
    localparam int DEF_DATA_WIDTH = 32;

    // capacity limit after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // operation codes carried in the input tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_TAIL = 3'd0,
        KIND_PUSH_HEAD = 3'd1,
        KIND_POP_TAIL  = 3'd2,
        KIND_POP_HEAD  = 3'd3,
        KIND_READ_POS  = 3'd4
    } t_kind;

    // result status carried in the output tuser
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_EMPTY  = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_BADPOS = 2'd3
    } t_status;

endpackage

// File: sv/bdq_ram.sv
// generic single-port-write ram with registered read
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/bounded_deque_with_indexed_read.sv
// bounded double-ended queue on a ring buffer with indexed read
//
//  channel  dir  beat fields (lsb first)
//  -------  ---  ---------------------------------------------------------
//  s        in   tuser: kind[2:0]; tdata: push_value[31:0], position[35:32]
//  m        out  tuser: status[1:0]; tdata: result_value[31:0], entry_count[36:32]
//  cfg      in   we + wdata: capacity_limit[4:0]
//
//  pushes, refused operations and unused kinds show their result in the cycle after
//  the beat is taken; a successful pop or read shows it only after the ST_READ state,
//  set by the registered read of the entry ram, and the slave side is closed in ST_READ.
//  a new beat is taken only when the result register is empty or its beat leaves
//  in the same cycle, so a stalled master holds the slave side while a result waits.
//  reset (synchronous, active low) empties the queue and sets the limit to 16;
//  the entry ram is not cleared, only written slots are ever read.
module bounded_deque_with_indexed_read #(
    parameter int DEPTH      = bdq_pkg::DEF_DEPTH,
    parameter int DATA_WIDTH = bdq_pkg::DEF_DATA_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // capacity limit register
    input  logic                            i_cfg_we,
    input  logic [bdq_pkg::CAP_W-1:0]       i_cfg_wdata,
    // operation beats
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [bdq_pkg::IN_DATA_W-1:0]   i_s_tdata,  // push_value[31:0], position[35:32]
    input  logic [bdq_pkg::KIND_W-1:0]      i_s_tuser,  // kind[2:0]
    // result beats
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [bdq_pkg::OUT_DATA_W-1:0]  o_m_tdata,  // result_value[31:0], entry_count[36:32]
    output logic [bdq_pkg::STATUS_W-1:0]    o_m_tuser   // status[1:0]
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > bdq_pkg::CAP_W) ? CW : bdq_pkg::CAP_W;
    localparam int PW   = (AW > bdq_pkg::POS_W) ? AW : bdq_pkg::POS_W;
    localparam int XW   = (DATA_WIDTH > bdq_pkg::VALUE_W) ? DATA_WIDTH : bdq_pkg::VALUE_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } t_state;

    t_state                         r_state, n_state;
    logic [AW-1:0]                  r_head, n_head;
    logic [CW-1:0]                  r_count, n_count;
    logic [bdq_pkg::CAP_W-1:0]      r_cap;
    logic                           r_out_valid;
    logic [bdq_pkg::VALUE_W-1:0]    r_out_value;
    logic [bdq_pkg::STATUS_W-1:0]   r_out_status;
    logic [bdq_pkg::COUNT_W-1:0]    r_out_count;

    logic                           s_fire, m_fire;
    logic [bdq_pkg::VALUE_W-1:0]    push_value;
    logic [bdq_pkg::POS_W-1:0]      position;
    logic [PW-1:0]                  pos_ext;
    logic                           is_full, is_empty, pos_bad;
    logic                           need_read;
    bdq_pkg::t_status               op_status;
    logic                           ram_we, ram_re;
    logic [AW-1:0]                  ram_waddr, ram_raddr;
    logic [DATA_WIDTH-1:0]          ram_wdata, ram_rdata;
    logic [XW-1:0]                  wdata_ext, rdata_ext;

    // ring slot offs places after base, both below DEPTH
    function automatic logic [AW-1:0] slot_after(input logic [AW-1:0] base,
                                                 input logic [AW-1:0] offs);
        logic [AW:0] s;
        s = {1'b0, base} + {1'b0, offs};
        if (s >= (AW+1)'(DEPTH)) begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // beat handshakes
    assign o_s_tready = (r_state == ST_IDLE) && (!r_out_valid || i_m_tready);
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign m_fire     = r_out_valid && i_m_tready;

    // input fields
    assign push_value = i_s_tdata[bdq_pkg::VALUE_W-1:0];
    assign position   = i_s_tdata[bdq_pkg::VALUE_W +: bdq_pkg::POS_W];
    assign pos_ext    = PW'(position);

    // occupancy checks
    assign is_full  = (CMPW'(r_count) >= CMPW'(r_cap)) || (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);
    assign pos_bad  = (CMPW'(position) >= CMPW'(r_count));

    // data width adaption between the stream and the ram
    assign wdata_ext = XW'(push_value);
    assign ram_wdata = wdata_ext[DATA_WIDTH-1:0];
    assign rdata_ext = XW'(ram_rdata);

    // operation decode: pointer update and ram access
    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        ram_we    = 1'b0;
        ram_waddr = r_head;
        ram_re    = 1'b0;
        ram_raddr = r_head;
        need_read = 1'b0;
        op_status = bdq_pkg::STAT_OK;
        if (s_fire) begin
            unique case (i_s_tuser)
                bdq_pkg::KIND_PUSH_TAIL: begin
                    if (is_full) begin
                        op_status = bdq_pkg::STAT_FULL;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = slot_after(r_head, AW'(r_count));
                        n_count   = r_count + CW'(1);
                    end
                end
                bdq_pkg::KIND_PUSH_HEAD: begin
                    if (is_full) begin
                        op_status = bdq_pkg::STAT_FULL;
                    end else begin
                        n_head    = slot_after(r_head, AW'(DEPTH - 1));
                        ram_we    = 1'b1;
                        ram_waddr = n_head;
                        n_count   = r_count + CW'(1);
                    end
                end
                bdq_pkg::KIND_POP_TAIL: begin
                    if (is_empty) begin
                        op_status = bdq_pkg::STAT_EMPTY;
                    end else begin
                        n_count   = r_count - CW'(1);
                        ram_re    = 1'b1;
                        ram_raddr = slot_after(r_head, AW'(n_count));
                        need_read = 1'b1;
                    end
                end
                bdq_pkg::KIND_POP_HEAD: begin
                    if (is_empty) begin
                        op_status = bdq_pkg::STAT_EMPTY;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = r_head;
                        n_head    = slot_after(r_head, AW'(1));
                        n_count   = r_count - CW'(1);
                        need_read = 1'b1;
                    end
                end
                bdq_pkg::KIND_READ_POS: begin
                    if (pos_bad) begin
                        op_status = bdq_pkg::STAT_BADPOS;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = slot_after(r_head, pos_ext[AW-1:0]);
                        need_read = 1'b1;
                    end
                end
                default: begin
                    // unused kinds leave everything as it is
                end
            endcase
        end
    end

    // sequencer: wait in ST_READ for ram data on pops and reads
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_fire && need_read) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_cap       <= bdq_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if ((s_fire && !need_read) || (r_state == ST_READ)) begin
                r_out_valid <= 1'b1;
            end else if (m_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload: status and count at accept, data once the ram answers
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_out_value  <= '0;
            r_out_status <= op_status;
            r_out_count  <= bdq_pkg::COUNT_W'(n_count);
        end else if (r_state == ST_READ) begin
            r_out_value <= rdata_ext[bdq_pkg::VALUE_W-1:0];
        end
    end

    bdq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // result beat
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = bdq_pkg::OUT_DATA_W'({r_out_count, r_out_value});

endmodule

// File: sv/bdq_chk.sv
// port-level checks for the bounded deque, bound to the top level
module bdq_chk #(
    parameter int DEPTH = bdq_pkg::DEF_DEPTH
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [bdq_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    input logic [bdq_pkg::STATUS_W-1:0]    o_m_tuser
);

    logic [bdq_pkg::VALUE_W-1:0] m_value;
    logic [bdq_pkg::COUNT_W-1:0] m_count;

    assign m_value = o_m_tdata[bdq_pkg::VALUE_W-1:0];
    assign m_count = o_m_tdata[bdq_pkg::VALUE_W +: bdq_pkg::COUNT_W];

    // no result beat right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result beat shown right after reset");

    // a stalled result beat holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result beat changed");

    // a refused operation carries a zero data word
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != bdq_pkg::STAT_OK) |-> m_value == '0)
        else $error("nonzero data word with error status");

    // an empty status only comes from an empty queue
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == bdq_pkg::STAT_EMPTY) |-> m_count == '0)
        else $error("empty status with entries held");

    // the count never exceeds the ring depth
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (DEPTH > 31) || (int'(m_count) <= DEPTH))
        else $error("entry count above ring depth");

endmodule

bind bounded_deque_with_indexed_read bdq_chk #(
    .DEPTH (DEPTH)
) u_bdq_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// File: tb/tb_bounded_deque_with_indexed_read.sv
// testbench for the bounded deque: directed and random operations against a local predictor
module tb_bounded_deque_with_indexed_read;
    import bdq_pkg::*;

    localparam int RING_DEPTH  = DEF_DEPTH;
    localparam int RING_AW     = $clog2(RING_DEPTH);
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 4;

    // kinds beyond the defined operations, expected to be ignored
    localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_deque_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CAP_W-1:0]       i_cfg_wdata = '0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_DATA_W-1:0]   i_s_tdata = '0;   // push_value[31:0], position[35:32]
    logic [KIND_W-1:0]      i_s_tuser = '0;   // kind[2:0]
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  o_m_tdata;        // result_value[31:0], entry_count[36:32]
    logic [STATUS_W-1:0]    o_m_tuser;        // status[1:0]

    // predictor state of the ring
    logic [VALUE_W-1:0] model_mem [RING_DEPTH];
    int                 model_head = 0;
    int                 model_count = 0;
    int                 model_cap = int'(CAP_RESET);

    t_deque_result      expected_results [$];
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 mismatch_count = 0;
    int                 ops_sent = 0;
    int                 results_seen = 0;
    int                 status_seen [4] = '{0, 0, 0, 0};
    int                 peak_count = 0;
    int                 cap_writes = 0;
    int                 cycle_count = 0;

    bounded_deque_with_indexed_read uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_results.size());
            $display("tb_bounded_deque_with_indexed_read: FAIL");
            $finish;
        end
    end

    // receiver backpressure
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string what, input logic [39:0] want,
                                   input logic [39:0] got);
        $display("mismatch at cycle %0d: %s expected %h got %h",
                 cycle_count, what, want, got);
        mismatch_count++;
    endtask

    // compare each result beat with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_deque_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            status_seen[o_m_tuser]++;
            if (expected_results.size() == 0) begin
                report_mismatch("result beat with nothing pending", '0,
                                {o_m_tuser, o_m_tdata[37:0]});
            end else begin
                want = expected_results.pop_front();
                if (o_m_tdata[31:0] !== want.value)
                    report_mismatch("result_value", 40'(want.value), 40'(o_m_tdata[31:0]));
                if (o_m_tuser !== want.status)
                    report_mismatch("status", 40'(want.status), 40'(o_m_tuser));
                if (o_m_tdata[36:32] !== want.count)
                    report_mismatch("entry_count", 40'(want.count), 40'(o_m_tdata[36:32]));
            end
        end
    end

    // deque behavior: apply one operation to the local ring, return its result
    function automatic t_deque_result deque_apply(input logic [KIND_W-1:0] kind,
                                                  input logic [VALUE_W-1:0] word,
                                                  input logic [POS_W-1:0] pos);
        t_deque_result      r;
        int                 room;
        logic [RING_AW-1:0] idx;
        room = (model_cap > RING_DEPTH) ? RING_DEPTH : model_cap;
        r.value  = '0;
        r.status = STAT_OK;
        idx      = '0;
        case (kind)
            KIND_PUSH_TAIL: begin
                if (model_count >= room) begin
                    r.status = STAT_FULL;
                end else begin
                    idx = RING_AW'((model_head + model_count) % RING_DEPTH);
                    model_mem[idx] = word;
                    model_count++;
                end
            end
            KIND_PUSH_HEAD: begin
                if (model_count >= room) begin
                    r.status = STAT_FULL;
                end else begin
                    model_head = (model_head + RING_DEPTH - 1) % RING_DEPTH;
                    idx = RING_AW'(model_head);
                    model_mem[idx] = word;
                    model_count++;
                end
            end
            KIND_POP_TAIL: begin
                if (model_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    model_count--;
                    idx = RING_AW'((model_head + model_count) % RING_DEPTH);
                    r.value = model_mem[idx];
                end
            end
            KIND_POP_HEAD: begin
                if (model_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    idx = RING_AW'(model_head);
                    r.value = model_mem[idx];
                    model_head = (model_head + 1) % RING_DEPTH;
                    model_count--;
                end
            end
            KIND_READ_POS: begin
                if (int'(pos) >= model_count) begin
                    r.status = STAT_BADPOS;
                end else begin
                    idx = RING_AW'((model_head + int'(pos)) % RING_DEPTH);
                    r.value = model_mem[idx];
                end
            end
            default: ;
        endcase
        r.count = model_count[COUNT_W-1:0];
        return r;
    endfunction

    // send one operation beat, record its expected result on acceptance
    task automatic send_op(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] word,
                           input logic [POS_W-1:0] pos);
        t_deque_result exp_r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {4'b0, pos, word};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        exp_r = deque_apply(kind, word, pos);
        expected_results = {expected_results, exp_r};
        ops_sent++;
        if (model_count > peak_count)
            peak_count = model_count;
    endtask

    // stop sending and wait for every pending result
    task automatic hold_until_drained();
        i_s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // capacity register write, only with the queue idle
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        hold_until_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        model_cap = int'(cap);
        cap_writes++;
    endtask

    // pops, reads and spare kinds on a freshly reset queue
    task automatic test_empty_queue();
        send_op(KIND_POP_TAIL, 32'hDEAD_BEEF, 4'd0);
        send_op(KIND_POP_HEAD, 32'h0, 4'd0);
        send_op(KIND_READ_POS, 32'h0, 4'd0);
        send_op(KIND_SPARE_FIRST, 32'hFFFF_FFFF, 4'hF);
        send_op(KIND_SPARE_FIRST + 3'd1, 32'h1234_5678, 4'd3);
        send_op(KIND_SPARE_LAST, 32'h0, 4'd0);
    endtask

    // pushes at both ends, in-range and out-of-range reads, pops at both ends
    task automatic test_basic_ops();
        send_op(KIND_PUSH_TAIL, 32'hFFFF_FFFF, 4'hF);
        send_op(KIND_PUSH_HEAD, 32'h0000_0000, 4'd0);
        send_op(KIND_PUSH_TAIL, 32'hA5A5_5A5A, 4'd7);
        send_op(KIND_READ_POS, 32'hFFFF_FFFF, 4'd0);
        send_op(KIND_READ_POS, 32'h0, 4'd2);
        send_op(KIND_READ_POS, 32'h0, 4'd3);
        send_op(KIND_READ_POS, 32'h0, 4'hF);
        send_op(KIND_POP_TAIL, 32'h0, 4'd0);
        send_op(KIND_POP_HEAD, 32'h0, 4'd0);
        send_op(KIND_POP_HEAD, 32'h0, 4'd0);
    endtask

    // zero capacity, filling a small capacity, limit lowered below the count
    task automatic test_capacity_edges();
        set_capacity(5'd0);
        send_op(KIND_PUSH_TAIL, 32'h1111_1111, 4'd0);
        send_op(KIND_PUSH_HEAD, 32'h2222_2222, 4'd0);
        set_capacity(5'd2);
        send_op(KIND_PUSH_TAIL, 32'h3333_3333, 4'd0);
        send_op(KIND_PUSH_HEAD, 32'h4444_4444, 4'd0);
        send_op(KIND_PUSH_TAIL, 32'h5555_5555, 4'd0);
        set_capacity(5'd1);
        send_op(KIND_PUSH_HEAD, 32'h6666_6666, 4'd0);
        send_op(KIND_READ_POS, 32'h0, 4'd1);
        send_op(KIND_POP_TAIL, 32'h0, 4'd0);
        send_op(KIND_POP_HEAD, 32'h0, 4'd0);
    endtask

    // one random operation; push_pct steers the fill level
    task automatic send_random_op(input int push_pct);
        logic [VALUE_W-1:0] word;
        logic [POS_W-1:0]   pos;
        int                 pick;
        word = $urandom;
        pos  = POS_W'($urandom_range(15));
        if ($urandom_range(15) == 0)
            word = $urandom_range(1) ? '1 : '0;
        pick = $urandom_range(99);
        if (pick < 3) begin
            send_op(3'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST)), word, pos);
        end else if (pick < 25) begin
            // mostly positions inside the held range
            if (model_count > 0 && $urandom_range(3) != 0)
                pos = POS_W'($urandom_range(model_count - 1));
            send_op(KIND_READ_POS, word, pos);
        end else if ($urandom_range(99) < push_pct) begin
            send_op($urandom_range(1) ? KIND_PUSH_HEAD : KIND_PUSH_TAIL, word, pos);
        end else begin
            send_op($urandom_range(1) ? KIND_POP_HEAD : KIND_POP_TAIL, word, pos);
        end
    endtask

    // random traffic under one idle setting and capacity; fill and drain in bursts
    task automatic test_random_phase(input int send_pct, input int recv_pct,
                                     input logic [CAP_W-1:0] cap, input int n_ops);
        set_capacity(cap);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < n_ops; i++) begin
            send_random_op(((i / 48) % 2 == 0) ? 80 : 25);
            // sender pause until the queue has answered everything
            if (i == n_ops / 2)
                hold_until_drained();
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_queue();
        test_basic_ops();
        test_capacity_edges();
        test_random_phase(0, 0, 5'd31, 480);
        test_random_phase(62, 0, 5'd16, 490);
        test_random_phase(0, 62, 5'($urandom_range(15, 1)), 490);
        test_random_phase(6, 6, 5'($urandom_range(30, 17)), 490);

        hold_until_drained();
        repeat (DRAIN_WAIT * 4) @(posedge i_clk);

        $display("ran %0d operations, %0d results, %0d capacity writes, peak fill %0d",
                 ops_sent, results_seen, cap_writes, peak_count);
        $display("statuses seen: ok %0d, empty %0d, full %0d, bad position %0d",
                 status_seen[STAT_OK], status_seen[STAT_EMPTY],
                 status_seen[STAT_FULL], status_seen[STAT_BADPOS]);
        if (mismatch_count == 0)
            $display("tb_bounded_deque_with_indexed_read: PASS");
        else
            $display("tb_bounded_deque_with_indexed_read: FAIL");
        $finish;
    end

endmodule
